/* rtl/frme_pkg.sv */
`default_nettype none

package frme_pkg;

	// panel geometry and pixel storage width
	localparam int PANEL_WIDTH  = 128;
	localparam int PANEL_HEIGHT = 296;
	localparam int PIXEL_BITS   = 16;

	localparam int FRAME_SIZE = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int ADDR_W     = $clog2(FRAME_SIZE);
	localparam int COL_W      = $clog2(PANEL_WIDTH);
	localparam int ROW_W      = $clog2(PANEL_HEIGHT);
	localparam int PORT_PIX_W = 16;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_ROTATION = 1'b0;

	// rotation codes
	localparam logic [1:0] ROT_0   = 2'd0;
	localparam logic [1:0] ROT_90  = 2'd1;
	localparam logic [1:0] ROT_180 = 2'd2;
	localparam logic [1:0] ROT_270 = 2'd3;

	// channel operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef logic [PIXEL_BITS-1:0] pixel_t;
	typedef logic [ADDR_W-1:0]     addr_t;

	// read request from the address generator
	typedef struct packed {
		addr_t addr;
		logic  last;
	} rd_req_t;

	// access control towards the frame store
	typedef struct packed {
		logic   load;
		pixel_t wr_pixel;
		logic   read;
		addr_t  rd_addr;
	} store_ctrl_t;

	// port pixel to stored width, keeping the low bits
	function automatic pixel_t to_store(input logic [PORT_PIX_W-1:0] p);
		logic [PIXEL_BITS+PORT_PIX_W-1:0] ext;
		ext = {{PIXEL_BITS{1'b0}}, p};
		return ext[PIXEL_BITS-1:0];
	endfunction

	// stored pixel to port width, keeping the low bits
	function automatic logic [PORT_PIX_W-1:0] to_port(input pixel_t p);
		logic [PIXEL_BITS+PORT_PIX_W-1:0] ext;
		ext = {{PORT_PIX_W{1'b0}}, p};
		return ext[PORT_PIX_W-1:0];
	endfunction

endpackage

`default_nettype wire

/* rtl/frme_if.sv */
`default_nettype none

// input channel: load or read transactions
interface frme_in_if;
	logic        valid;
	logic        ready;
	logic        operation;
	logic [15:0] pixel_in;

	modport source (output valid, output operation, output pixel_in, input ready);
	modport sink (input valid, input operation, input pixel_in, output ready);
endinterface

// output channel: panel-order pixels
interface frme_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] pixel_out;
	logic        last_pixel;

	modport source (output valid, output pixel_out, output last_pixel, input ready);
	modport sink (input valid, input pixel_out, input last_pixel, output ready);
endinterface

`default_nettype wire

/* rtl/frame_rotate_mirror_engine_unit.sv */
`default_nettype none

// channel   | dir | transaction              | payload
// ----------+-----+--------------------------+--------------------------
// feed      | in  | load or read request     | operation, pixel_in
// result    | out | one pixel per read       | pixel_out, last_pixel
// apb       | in  | rotation_mode at 0x0     | psel .. prdata, pready
//
// While feed ready is high, one transaction per cycle is accepted, loads and reads alike.
// A read result passes first through the index register behind the stride
// multiplier, then through the frame memory's read port.
// Reset clears the counters and the rotation; the frame memory is not cleared.
// When result stalls, the output register and the index stage hold and feed
// ready drops once both are full.

module frame_rotate_mirror_engine_unit
	import frme_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	frme_in_if.sink                    feed,
	frme_out_if.source                 result
);

	logic [1:0]  rotation_q;
	logic        reg_sel;
	rd_req_t     req;
	store_ctrl_t ctrl;
	pixel_t      rd_data;
	logic        v_s1;
	addr_t       addr_s1;
	logic        last_s1;
	logic        v_s2;
	logic        last_s2;
	logic        advance;
	logic        feed_acc;
	logic        read_acc;
	logic        load_acc;

	// configuration register
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == REG_ROTATION);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotation_q <= ROT_0;
		end else if (psel && penable && pwrite && reg_sel) begin
			rotation_q <= pwdata[1:0];
		end
	end

	assign prdata = reg_sel ? {{(APB_DATA_W-2){1'b0}}, rotation_q} : '0;

	// handshake decode
	assign advance  = !v_s2 || result.ready;
	assign feed.ready = !v_s1 || advance;
	assign feed_acc = feed.valid && feed.ready;
	assign read_acc = feed_acc && (feed.operation == OP_READ);
	assign load_acc = feed_acc && (feed.operation == OP_LOAD);

	frme_addr_gen u_addr_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (read_acc),
		.rotation (rotation_q),
		.req      (req)
	);

	// index stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (read_acc) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (read_acc) begin
			addr_s1 <= req.addr;
			last_s1 <= req.last;
		end
	end

	// memory access
	always_comb begin
		ctrl.load     = load_acc;
		ctrl.wr_pixel = to_store(feed.pixel_in);
		ctrl.read     = v_s1 && advance;
		ctrl.rd_addr  = addr_s1;
	end

	frme_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rd_data (rd_data)
	);

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && advance) begin
			last_s2 <= last_s1;
		end
	end

	assign result.valid      = v_s2;
	assign result.pixel_out  = to_port(rd_data);
	assign result.last_pixel = last_s2;

endmodule

`default_nettype wire

/* rtl/frme_addr_gen.sv */
`default_nettype none

module frme_addr_gen
	import frme_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       step,
	input  wire logic [1:0] rotation,
	output rd_req_t         req
);

	localparam logic [COL_W-1:0]  COL_MAX = COL_W'(PANEL_WIDTH - 1);
	localparam logic [ROW_W-1:0]  ROW_MAX = ROW_W'(PANEL_HEIGHT - 1);
	localparam logic [ADDR_W-1:0] W_A     = ADDR_W'(PANEL_WIDTH);
	localparam logic [ADDR_W-1:0] H_A     = ADDR_W'(PANEL_HEIGHT);

	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_rev;
	logic [ROW_W-1:0]  row_rev;
	logic [ADDR_W-1:0] mul_a;
	logic [ADDR_W-1:0] mul_b;
	logic [ADDR_W-1:0] offset;
	logic              col_end;
	logic              row_end;

	assign col_rev = COL_MAX - col_q;
	assign row_rev = ROW_MAX - row_q;
	assign col_end = (col_q == COL_MAX);
	assign row_end = (row_q == ROW_MAX);

	// panel position counters, column fastest
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// stride, line index and offset for each orientation
	always_comb begin
		unique case (rotation)
			ROT_90: begin
				mul_a  = ADDR_W'(col_q);
				mul_b  = H_A;
				offset = ADDR_W'(row_q);
			end
			ROT_180: begin
				mul_a  = ADDR_W'(row_rev);
				mul_b  = W_A;
				offset = ADDR_W'(col_q);
			end
			ROT_270: begin
				mul_a  = ADDR_W'(col_rev);
				mul_b  = H_A;
				offset = ADDR_W'(row_rev);
			end
			default: begin
				mul_a  = ADDR_W'(row_q);
				mul_b  = W_A;
				offset = ADDR_W'(col_rev);
			end
		endcase
	end

	assign req.addr = mul_a * mul_b + offset;
	assign req.last = col_end && row_end;

endmodule

`default_nettype wire

/* rtl/frme_store.sv */
`default_nettype none

module frme_store
	import frme_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  store_ctrl_t ctrl,
	output pixel_t      rd_data
);

	localparam logic [ADDR_W-1:0] LOAD_MAX = ADDR_W'(FRAME_SIZE - 1);

	pixel_t mem [FRAME_SIZE];
	addr_t  load_pos_q;
	pixel_t rd_q;

	// source pixels land in arrival order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
		end else if (ctrl.load) begin
			load_pos_q <= (load_pos_q == LOAD_MAX) ? '0 : load_pos_q + 1'b1;
		end
	end

	// frame memory write port
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mem[load_pos_q] <= ctrl.wr_pixel;
		end
	end

	// registered read port, old data on a same-address write
	always_ff @(posedge clk) begin
		if (ctrl.read) begin
			rd_q <= mem[ctrl.rd_addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

/* dv/frame_rotate_mirror_engine_unit_tb.sv */
`default_nettype none

module frame_rotate_mirror_engine_unit_tb;
	import frme_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	// generous ceiling: every item worst gap, worst stall and pipeline, several times over
	localparam int CYCLE_LIMIT = 8_000_000;
	// cycles the read pipeline may still be busy once the last pixel is out
	localparam int SETTLE_CYCLES = 6;
	localparam int RANDOM_ITEMS = 1150;
	localparam logic [APB_ADDR_W-1:0] ROT_ADDR = APB_ADDR_W'(4 * REG_ROTATION);

	typedef enum int {SINK_FREE, SINK_LIGHT, SINK_HEAVY} sink_style_e;

	typedef struct packed {
		logic [15:0] pixel;
		logic        last;
	} panel_pixel_t;

	// mirror of the frame store and panel walk, with the queue of pixels owed
	class panel_scoreboard;
		pixel_t       store [FRAME_SIZE];
		int unsigned  load_pos = 0;
		int unsigned  row = 0;
		int unsigned  col = 0;
		logic [1:0]   rotation = ROT_0;
		panel_pixel_t due [$];
		int           errors = 0;

		// source index for panel row y, column c; rotation 0 carries the row mirror
		function int unsigned source_addr(int unsigned y, int unsigned c);
			case (rotation)
				ROT_90:  return c * PANEL_HEIGHT + y;
				ROT_180: return (PANEL_HEIGHT - 1 - y) * PANEL_WIDTH + c;
				ROT_270: return (PANEL_WIDTH - 1 - c) * PANEL_HEIGHT + (PANEL_HEIGHT - 1 - y);
				default: return y * PANEL_WIDTH + (PANEL_WIDTH - 1 - c);
			endcase
		endfunction

		function int pending();
			return due.size();
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		// accepted feed transaction: store a load, or work out the panel pixel of a read
		function void note_feed(logic op, logic [15:0] pix);
			panel_pixel_t owed;
			if (op == OP_LOAD) begin
				store[load_pos] = pixel_t'(pix);
				load_pos = (load_pos + 1 == FRAME_SIZE) ? 0 : load_pos + 1;
			end else begin
				owed.pixel = 16'(store[source_addr(row, col)]);
				owed.last = (row == PANEL_HEIGHT - 1) && (col == PANEL_WIDTH - 1);
				due.push_back(owed);
				col++;
				if (col == PANEL_WIDTH) begin
					col = 0;
					row = (row + 1 == PANEL_HEIGHT) ? 0 : row + 1;
				end
			end
		endfunction

		// accepted result transaction against the oldest owed pixel
		function void check_panel_pixel(logic [15:0] pix, logic last);
			panel_pixel_t owed;
			if (due.size() == 0) begin
				report($sformatf("result with no read outstanding: pixel %h last %b", pix, last));
				return;
			end
			owed = due.pop_front();
			if (pix !== owed.pixel)
				report($sformatf("pixel_out expected %h actual %h", owed.pixel, pix));
			if (last !== owed.last)
				report($sformatf("last_pixel expected %b actual %b", owed.last, last));
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	frme_in_if  feed_ch ();
	frme_out_if result_ch ();

	panel_scoreboard sb;
	sink_style_e     sink_style = SINK_FREE;
	bit              steady = 1'b1;
	int              burst_left = 0;
	int              cycle_count = 0;

	frame_rotate_mirror_engine_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.feed    (feed_ch),
		.result  (result_ch)
	);

	// clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// transaction monitor and watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (feed_ch.valid && feed_ch.ready)
			sb.note_feed(feed_ch.operation, feed_ch.pixel_in);
		if (result_ch.valid && result_ch.ready)
			sb.check_panel_pixel(result_ch.pixel_out, result_ch.last_pixel);
		if (cycle_count == CYCLE_LIMIT) begin
			$display("frame_rotate_mirror_engine_unit regression: fail");
			$finish;
		end
	end

	// result receiver: stalls of its own, heavier or lighter by phase
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				case (sink_style)
					SINK_LIGHT: if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(1, 4);
					SINK_HEAVY: if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 12);
					default: ;
				endcase
			end
		end
	end

	// sender bursts with random gaps in between
	task automatic pace();
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : $urandom_range(0, 6);
			if (gap > 0) begin
				feed_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
	endtask

	// one feed transaction, returns at the falling edge after acceptance
	task automatic send(input logic op, input logic [15:0] pix);
		pace();
		feed_ch.valid     <= 1'b1;
		feed_ch.operation <= op;
		feed_ch.pixel_in  <= pix;
		@(posedge clk);
		while (!feed_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// hold the feed until every owed pixel is out and the pipeline is quiet
	task automatic wait_idle();
		feed_ch.valid <= 1'b0;
		burst_left = 0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// register write over apb, only with the block idle
	task automatic program_orientation(input logic [1:0] mode);
		wait_idle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ROT_ADDR;
		pwdata  <= {{(APB_DATA_W - 2){1'b0}}, mode};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.rotation = mode;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_run(input logic [1:0] mode, input int count);
		program_orientation(mode);
		repeat (count) send(OP_READ, 16'($urandom));
	endtask

	initial begin
		int          k;
		int          next_change;
		logic [15:0] pix;

		sb = new();
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		feed_ch.valid = 1'b0;
		feed_ch.operation = OP_LOAD;
		feed_ch.pixel_in = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// whole frame first so that no read ever hits an unwritten entry
		program_orientation(ROT_0);
		for (k = 0; k < FRAME_SIZE; k++) begin
			case (k)
				0: pix = 16'h0000;
				1: pix = 16'hFFFF;
				2: pix = 16'hAAAA;
				3: pix = 16'h5555;
				FRAME_SIZE - 1: pix = 16'hFFFF;
				default: pix = 16'($urandom);
			endcase
			if (k == 3000)
				steady = 1'b0;
			send(OP_LOAD, pix);
		end

		// short runs of reads in every rotation, switched part way through a frame
		sink_style = SINK_LIGHT;
		read_run(ROT_0, 4);
		read_run(ROT_90, 4);
		read_run(ROT_180, 4);
		read_run(ROT_270, 4);
		read_run(ROT_0, 4);

		// read sweep past the end of the frame and into the next one
		for (k = 0; k < 4; k++) begin
			sink_style = sink_style_e'(k % 3);
			steady = (k == 2);
			read_run(2'($urandom_range(0, 3)), FRAME_SIZE / 4);
		end

		// loads and reads mixed, rotation and pacing reshuffled from time to time
		sink_style = SINK_HEAVY;
		steady = 1'b0;
		next_change = $urandom_range(100, 250);
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			if (k == next_change) begin
				program_orientation(2'($urandom_range(0, 3)));
				sink_style = sink_style_e'($urandom_range(0, 2));
				steady = ($urandom_range(0, 3) == 0);
				next_change += $urandom_range(100, 250);
			end
			if ($urandom_range(0, 7) == 0)
				pix = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			else
				pix = 16'($urandom);
			send($urandom_range(0, 1) ? OP_READ : OP_LOAD, pix);
		end

		wait_idle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("frame_rotate_mirror_engine_unit regression: pass");
		else
			$display("frame_rotate_mirror_engine_unit regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
